FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the resampler RTL.
// Included by modules that carry concurrent checks; needs no other file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ARL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ARL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/arl_pkg.sv
// Types, constants and helpers of the resampler with one-pole low-pass.
// Used by every module of the block; depends on nothing.
`default_nettype none

package arl_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COUNT_W    = 21;
  localparam int STEP_W     = 16;
  localparam int ALPHA_W    = 17;
  localparam int CFG_DATA_W = 21;
  localparam int POS_FRAC   = 8;       // fraction bits of the output position
  localparam int MAX_OUT_DEF = 1048576;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [STEP_W-1:0]  STEP_MIN  = STEP_W'(4);
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);
  localparam logic [COUNT_W-1:0] INDEX_MAX = {COUNT_W{1'b1}};
  localparam logic [SAMPLE_W-1:0] HALF_SCALE = SAMPLE_W'(32768);

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_WIDE  = 2'd0,
    CFG_STEP  = 2'd1,
    CFG_COUNT = 2'd2,
    CFG_ALPHA = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic                wide_samples;
    logic [STEP_W-1:0]   step_ratio;
    logic [COUNT_W-1:0]  out_count;
    logic [ALPHA_W-1:0]  filter_alpha;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] raw_sample;
    logic                start_of_sound;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_of_run;
    logic                       last_of_sound;
  } out_item_t;

  // Widened sample as it travels from front end to back end
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x;
    logic                       start;
  } q_item_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_MUL  = 2'd1,
    ST_EMIT = 2'd2
  } back_state_t;

  // Byte b becomes b*257-32768, i.e. {b,b} with the top bit flipped
  function automatic logic signed [SAMPLE_W-1:0] widen(input logic wide,
                                                       input logic [SAMPLE_W-1:0] raw);
    logic [SAMPLE_W-1:0] narrow;
    narrow = {raw[7:0], raw[7:0]} ^ HALF_SCALE;
    return wide ? $signed(raw) : $signed(narrow);
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/arl_front.sv
// Front end: accepts source samples, widens them and stages them for the queue.
// Depends on arl_pkg.
`default_nettype none

module arl_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wide_samples,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire arl_pkg::in_item_t in_data,
  output logic                   push,
  output arl_pkg::q_item_t       push_item,
  input  wire logic              q_ready
);

  logic              stg_valid_r, stg_valid_nxt;
  arl_pkg::q_item_t  stg_r;
  logic              in_xfer;

  // Stage frees when its item moves into the queue
  assign in_ready  = !stg_valid_r || q_ready;
  assign in_xfer   = in_valid && in_ready;
  assign push      = stg_valid_r && q_ready;
  assign push_item = stg_r;

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (in_xfer) begin
      stg_valid_nxt = 1'b1;
    end else if (push) begin
      stg_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
    end
  end

  // Payload: widen on the way in
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      stg_r.x     <= arl_pkg::widen(wide_samples, in_data.raw_sample);
      stg_r.start <= in_data.start_of_sound;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/arl_queue.sv
// Short FIFO between front and back end so each side stalls on its own.
// Depends on arl_pkg.
`default_nettype none

module arl_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire arl_pkg::q_item_t push_item,
  output logic                  q_ready,
  input  wire logic             pop,
  output logic                  q_valid,
  output arl_pkg::q_item_t      q_item
);

  localparam int DEPTH = arl_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  arl_pkg::q_item_t  slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign q_ready = (cnt_r != CNT_W'(DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = slot_r[rd_ptr_r];
  assign do_push = push && q_ready;
  assign do_pop  = pop && q_valid;

  // Pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/arl_back.sv
// Back end: position tracking, floor-index sample selection, low-pass and result register.
// Depends on arl_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module arl_back #(
  parameter int MAX_OUT = arl_pkg::MAX_OUT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire arl_pkg::cfg_t     cfg,
  input  wire logic              q_valid,
  input  wire arl_pkg::q_item_t  q_item,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output arl_pkg::out_item_t     out_data
);

  localparam int COUNT_W  = arl_pkg::COUNT_W;
  localparam int SAMPLE_W = arl_pkg::SAMPLE_W;
  localparam int STEP_W   = arl_pkg::STEP_W;
  localparam int ALPHA_W  = arl_pkg::ALPHA_W;
  localparam int POS_FRAC = arl_pkg::POS_FRAC;
  localparam int CNT_MAX  = (1 << COUNT_W) - 1;
  localparam int CLIP_INT = (MAX_OUT > CNT_MAX) ? CNT_MAX : MAX_OUT;
  localparam logic [COUNT_W-1:0] MAX_CLIP = COUNT_W'(CLIP_INT);
  // Position never exceeds count * step; keep room to compare against the index
  localparam int POS_BITS = $clog2(CLIP_INT + 1) + STEP_W;
  localparam int POS_MIN  = COUNT_W + POS_FRAC;
  localparam int POS_W    = (POS_BITS > POS_MIN) ? POS_BITS : POS_MIN;
  localparam int DIFF_W   = SAMPLE_W + 1;
  localparam int PROD_W   = ALPHA_W + 1 + DIFF_W;

  arl_pkg::back_state_t         state_r, state_nxt;
  logic [COUNT_W-1:0]           idx_r, idx_nxt;
  logic [POS_W-1:0]             pos_r, pos_nxt;
  logic [COUNT_W-1:0]           emit_r, emit_nxt;
  logic signed [SAMPLE_W-1:0]   prev_r, prev_nxt;
  logic                         first_r, first_nxt;
  logic signed [SAMPLE_W-1:0]   x_r, x_nxt;
  logic signed [PROD_W-1:0]     prod_r, prod_nxt;
  logic                         out_valid_r, out_valid_nxt;
  arl_pkg::out_item_t           out_r, out_nxt;

  logic [STEP_W-1:0]            step;
  logic [COUNT_W-1:0]           limit;
  logic [ALPHA_W-1:0]           alpha;
  logic                         run_ok;
  logic [POS_W-1:0]             pos_step;
  logic [COUNT_W-1:0]           emit_inc;
  logic [COUNT_W-1:0]           idx_inc;
  logic                         last_run;
  logic signed [DIFF_W-1:0]     diff;
  logic signed [PROD_W-1:0]     product;
  logic signed [PROD_W-1:0]     acc;
  logic signed [PROD_W-17:0]    quot;
  logic signed [SAMPLE_W-1:0]   filt;
  logic signed [SAMPLE_W-1:0]   y;
  logic                         out_load;

  // Clipped configuration
  assign step  = (cfg.step_ratio < arl_pkg::STEP_MIN) ? arl_pkg::STEP_MIN : cfg.step_ratio;
  assign limit = (cfg.out_count > MAX_CLIP) ? MAX_CLIP : cfg.out_count;
  assign alpha = (cfg.filter_alpha > arl_pkg::ALPHA_ONE) ? arl_pkg::ALPHA_ONE
                                                         : cfg.filter_alpha;

  // Selection: does the next output land on the current source index
  assign run_ok   = (emit_r < limit) &&
                    (pos_r[POS_W-1:POS_FRAC] == (POS_W-POS_FRAC)'(idx_r));
  assign pos_step = pos_r + POS_W'(step);
  assign emit_inc = emit_r + 1'b1;
  assign idx_inc  = (idx_r == arl_pkg::INDEX_MAX) ? idx_r : idx_r + 1'b1;
  assign last_run = !((emit_inc < limit) &&
                      (pos_step[POS_W-1:POS_FRAC] == (POS_W-POS_FRAC)'(idx_r)));

  // Low-pass: y = trunc((65536*prev + alpha*(x - prev)) / 65536)
  assign diff    = DIFF_W'(x_r) - DIFF_W'(prev_r);
  assign product = $signed({1'b0, alpha}) * diff;
  assign acc     = {{(PROD_W-SAMPLE_W-16){prev_r[SAMPLE_W-1]}}, prev_r, 16'b0} + prod_r;
  assign quot    = acc[PROD_W-1:16] + ((acc[PROD_W-1] && (acc[15:0] != '0)) ? 1'b1 : 1'b0);
  assign filt    = quot[SAMPLE_W-1:0];
  assign y       = first_r ? filt : x_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Sequencer: fetch, multiply, emit
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    emit_nxt  = emit_r;
    prev_nxt  = prev_r;
    first_nxt = first_r;
    x_nxt     = x_r;
    prod_nxt  = prod_r;
    q_pop     = 1'b0;
    out_load  = 1'b0;
    out_nxt.sample        = y;
    out_nxt.last_of_run   = last_run;
    out_nxt.last_of_sound = (emit_inc == limit);
    case (state_r)
      arl_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          x_nxt = q_item.x;
          if (q_item.start) begin
            idx_nxt   = '0;
            pos_nxt   = '0;
            emit_nxt  = '0;
            prev_nxt  = '0;
            first_nxt = 1'b0;
          end
          state_nxt = arl_pkg::ST_MUL;
        end
      end
      arl_pkg::ST_MUL: begin
        if (run_ok) begin
          prod_nxt  = product;
          state_nxt = arl_pkg::ST_EMIT;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = arl_pkg::ST_IDLE;
        end
      end
      arl_pkg::ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          prev_nxt  = y;
          first_nxt = 1'b1;
          pos_nxt   = pos_step;
          emit_nxt  = emit_inc;
          if (last_run) begin
            idx_nxt   = idx_inc;
            state_nxt = arl_pkg::ST_IDLE;
          end else begin
            state_nxt = arl_pkg::ST_MUL;
          end
        end
      end
      default: begin
        state_nxt = arl_pkg::ST_IDLE;
      end
    endcase
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= arl_pkg::ST_IDLE;
      idx_r       <= '0;
      pos_r       <= '0;
      emit_r      <= '0;
      prev_r      <= '0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      pos_r       <= pos_nxt;
      emit_r      <= emit_nxt;
      prev_r      <= prev_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    prod_r <= prod_nxt;
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  // Checks
  `ARL_ASSERT_NEXT(a_prev_tracks_out, clk, rst_n, out_load, prev_r == out_r.sample, "filter state differs from emitted sample")
  `ARL_ASSERT_IMPL(a_sound_end_ends_run, clk, rst_n, out_load && out_nxt.last_of_sound, out_nxt.last_of_run, "sound ended but run continues")
  `ARL_ASSERT_NEXT(a_emit_counts, clk, rst_n, out_load, emit_r == $past(emit_r) + 1'b1, "output count did not advance")

endmodule

`default_nettype wire

FILE: hw/rtl/audio_resample_lowpass_unit.sv
// An input sample goes through the front-end stage register and the queue; the back end
// fetches it, registers the filter multiply, then loads the result register once free.
// Per sample it spends a fetch state, per result a multiply and an emit state (with no
// result, only a multiply state), as the registered multiply feeds the next filter input.
// A 2-entry queue lets the input side keep accepting while results are in flight.
// Reset: synchronous, active-low rst_n; config returns to defaults, sound state clears.
`default_nettype none

module audio_resample_lowpass_unit #(
  parameter int MAX_OUT = arl_pkg::MAX_OUT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire arl_pkg::in_item_t                 in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output arl_pkg::out_item_t                     out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire arl_pkg::cfg_idx_t                 cfg_index,
  input  wire logic [arl_pkg::CFG_DATA_W-1:0]    cfg_data
);

  arl_pkg::cfg_t    cfg_r, cfg_nxt;
  logic             push;
  arl_pkg::q_item_t push_item;
  logic             q_ready;
  logic             q_valid;
  arl_pkg::q_item_t q_item;
  logic             q_pop;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        arl_pkg::CFG_WIDE:  cfg_nxt.wide_samples = cfg_data[0];
        arl_pkg::CFG_STEP:  cfg_nxt.step_ratio   = cfg_data[arl_pkg::STEP_W-1:0];
        arl_pkg::CFG_COUNT: cfg_nxt.out_count    = cfg_data[arl_pkg::COUNT_W-1:0];
        arl_pkg::CFG_ALPHA: cfg_nxt.filter_alpha = cfg_data[arl_pkg::ALPHA_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wide_samples <= 1'b0;
      cfg_r.step_ratio   <= arl_pkg::STEP_W'(64);
      cfg_r.out_count    <= '0;
      cfg_r.filter_alpha <= arl_pkg::ALPHA_W'(28836);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  arl_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .wide_samples (cfg_r.wide_samples),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .push         (push),
    .push_item    (push_item),
    .q_ready      (q_ready)
  );

  arl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .q_ready   (q_ready),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  arl_back #(
    .MAX_OUT (MAX_OUT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
